// File: design/i2cms_pkg.sv
package i2cms_pkg;

    localparam int STATUS_SHIFT = 3;

    // op codes
    localparam logic [1:0] OP_BEGIN_RD = 2'd0;
    localparam logic [1:0] OP_BEGIN_WR = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;

    // control bits
    localparam logic [2:0] CTL_STA = 3'b001;
    localparam logic [2:0] CTL_STO = 3'b010;
    localparam logic [2:0] CTL_AA  = 3'b100;

    // status entries (code >> 3)
    localparam logic [4:0] ST_BUS_ERR  = 5'd0;
    localparam logic [4:0] ST_START    = 5'd1;
    localparam logic [4:0] ST_RSTART   = 5'd2;
    localparam logic [4:0] ST_SLAW_ACK = 5'd3;
    localparam logic [4:0] ST_SLAW_NAK = 5'd4;
    localparam logic [4:0] ST_TXD_ACK  = 5'd5;
    localparam logic [4:0] ST_TXD_NAK  = 5'd6;
    localparam logic [4:0] ST_ARB_LOST = 5'd7;
    localparam logic [4:0] ST_SLAR_ACK = 5'd8;
    localparam logic [4:0] ST_SLAR_NAK = 5'd9;
    localparam logic [4:0] ST_RXD_ACK  = 5'd10;
    localparam logic [4:0] ST_RXD_NAK  = 5'd11;
    localparam logic [4:0] ST_SLV_LO   = 5'd12;
    localparam logic [4:0] ST_SLV_HI   = 5'd25;
    localparam logic [4:0] ST_INV_LO   = 5'd26;
    localparam logic [4:0] ST_INV_HI   = 5'd30;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] target_addr;
        logic [7:0] xfer_length;
        logic [7:0] status_code;
        logic [7:0] bus_data;
        logic [7:0] tx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] addr_byte;
        logic [7:0] read_remaining;
        logic [7:0] write_remaining;
        logic       finished;
    } t_state;

    typedef struct packed {
        logic [2:0] ctl_set;
        logic [2:0] ctl_clear;
        logic       dat_write_valid;
        logic [7:0] dat_write_value;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       slave_status;
        logic       invalid_status;
    } t_result;

endpackage

// File: design/i2c_master_status_sequencer_top.sv
// Channel | Direction | Handshake          | Words
// input   | in        | i_valid / o_stall  | op, target_addr, xfer_length, status_code,
//         |           |                    | bus_data, tx_byte
// result  | out       | o_valid / i_stall  | ctl_set ... invalid_status (one per input word)
//
// One word per cycle sustained while the result side does not stall; input register then result register.
// The decode and state update are combinational between those two registers.
// Reset clears both valid flags and sets state to idle with finished high.
// A stalled result holds; one more word is taken into the input register, then
// o_stall rises until the result register frees.
module i2c_master_status_sequencer_top import i2cms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [6:0] i_target_addr,
    input  logic [7:0] i_xfer_length,
    input  logic [7:0] i_status_code,
    input  logic [7:0] i_bus_data,
    input  logic [7:0] i_tx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_ctl_set,
    output logic [2:0] o_ctl_clear,
    output logic       o_dat_write_valid,
    output logic [7:0] o_dat_write_value,
    output logic       o_tx_taken,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic       o_done_res,
    output logic       o_slave_status,
    output logic       o_invalid_status
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    advance;
    logic    in_accept;

    i2cms_decode u_decode (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{addr_byte: 8'd0, read_remaining: 8'd0,
                             write_remaining: 8'd0, finished: 1'b1};
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= '{op: i_op, target_addr: i_target_addr, xfer_length: i_xfer_length,
                      status_code: i_status_code, bus_data: i_bus_data,
                      tx_byte: i_tx_byte};
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_ctl_set         = r_out.ctl_set;
    assign o_ctl_clear       = r_out.ctl_clear;
    assign o_dat_write_valid = r_out.dat_write_valid;
    assign o_dat_write_value = r_out.dat_write_value;
    assign o_tx_taken        = r_out.tx_taken;
    assign o_rx_valid        = r_out.rx_valid;
    assign o_rx_byte         = r_out.rx_byte;
    assign o_done_res        = r_out.done_res;
    assign o_slave_status    = r_out.slave_status;
    assign o_invalid_status  = r_out.invalid_status;

    a_set_clr_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ctl_set & o_ctl_clear) == 3'b000))
        else $error("ctl_set and ctl_clear overlap");

    a_done_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) |-> (o_done_res == r_state.finished))
        else $error("done_res differs from finished state");

    a_begin_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.op == OP_BEGIN_RD || r_in.op == OP_BEGIN_WR)
         && r_in.xfer_length != 8'd0) |=> (!r_state.finished && o_ctl_set == CTL_STA))
        else $error("begin word did not start a transaction");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("waiting input word lost");

    a_rx_no_dat_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rx_valid && o_dat_write_valid) && !(o_slave_status && o_invalid_status))
        else $error("conflicting result flags");

endmodule

// File: design/i2cms_decode.sv
module i2cms_decode import i2cms_pkg::*; (
    input  t_item   i_item,
    input  t_state  i_state,
    output t_result o_result,
    output t_state  o_state
);

    logic [4:0] idx;
    logic [7:0] rd_dec;

    assign idx    = i_item.status_code[7:STATUS_SHIFT];
    // read count, saturating at zero
    assign rd_dec = (i_state.read_remaining != 8'd0) ?
                    (i_state.read_remaining - 8'd1) : 8'd0;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.op == OP_BEGIN_RD || i_item.op == OP_BEGIN_WR) begin
            if (i_item.xfer_length == 8'd0) begin
                o_state.finished = 1'b1;
            end else begin
                o_state.addr_byte = {i_item.target_addr, (i_item.op == OP_BEGIN_RD)};
                if (i_item.op == OP_BEGIN_RD) begin
                    o_state.read_remaining = i_item.xfer_length;
                end else begin
                    o_state.write_remaining = i_item.xfer_length;
                end
                o_result.ctl_set = CTL_STA;
                o_state.finished = 1'b0;
            end
        end else if (i_item.op == OP_STATUS) begin
            case (idx)
                ST_BUS_ERR: begin
                    o_result.ctl_set = CTL_STO;
                end
                ST_START, ST_RSTART: begin
                    o_result.dat_write_valid = 1'b1;
                    o_result.dat_write_value = i_state.addr_byte;
                    o_result.ctl_set         = CTL_AA;
                    o_result.ctl_clear       = CTL_STA | CTL_STO;
                end
                ST_SLAW_ACK: begin
                    o_result.dat_write_valid = 1'b1;
                    o_result.dat_write_value = i_item.tx_byte;
                    o_result.ctl_set         = CTL_AA;
                    o_result.ctl_clear       = CTL_STA | CTL_STO;
                end
                ST_SLAW_NAK, ST_TXD_NAK: begin
                    o_result.ctl_set = CTL_STO;
                    o_state.finished = 1'b1;
                end
                ST_TXD_ACK: begin
                    o_result.tx_taken = 1'b1;
                    if (i_state.write_remaining <= 8'd1) begin
                        o_state.write_remaining = 8'd0;
                        o_result.ctl_clear      = CTL_STA;
                        o_result.ctl_set        = CTL_STO;
                        o_state.finished        = 1'b1;
                    end else begin
                        o_state.write_remaining  = i_state.write_remaining - 8'd1;
                        o_result.dat_write_valid = 1'b1;
                        o_result.dat_write_value = i_item.tx_byte;
                        o_result.ctl_set         = CTL_AA;
                        o_result.ctl_clear       = CTL_STA | CTL_STO;
                    end
                end
                ST_ARB_LOST: begin
                    o_result.ctl_set = CTL_STA;
                end
                ST_SLAR_ACK: begin
                    if (i_state.read_remaining == 8'd1) begin
                        o_result.ctl_clear = CTL_AA;
                    end else begin
                        o_result.ctl_set = CTL_AA;
                    end
                end
                ST_SLAR_NAK: begin
                    o_result.ctl_set = CTL_AA | CTL_STO;
                    o_state.finished = 1'b1;
                end
                ST_RXD_ACK: begin
                    o_result.rx_valid      = 1'b1;
                    o_result.rx_byte       = i_item.bus_data;
                    o_state.read_remaining = rd_dec;
                    // withhold ack ahead of the last byte
                    if (rd_dec == 8'd1) begin
                        o_result.ctl_clear = CTL_AA;
                    end else begin
                        o_result.ctl_set = CTL_AA;
                    end
                end
                ST_RXD_NAK: begin
                    o_result.rx_valid      = 1'b1;
                    o_result.rx_byte       = i_item.bus_data;
                    o_state.read_remaining = rd_dec;
                    o_result.ctl_set       = CTL_AA | CTL_STO;
                    o_state.finished       = 1'b1;
                end
                default: begin
                    if (idx inside {[ST_SLV_LO:ST_SLV_HI]}) begin
                        o_result.slave_status = 1'b1;
                    end else if (idx inside {[ST_INV_LO:ST_INV_HI]}) begin
                        o_result.invalid_status = 1'b1;
                    end
                end
            endcase
        end
        o_result.done_res = o_state.finished;
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cms_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [4:0] ST_NO_ACTION = 5'd31;
    localparam int WORD_TARGET = 400;
    localparam int IDLE_LIMIT = 2000;

    // Status decoder and transaction state tracking; holds expected result words.
    class status_scoreboard;
        logic [7:0] addr_q;
        logic [7:0] rd_left;
        logic [7:0] wr_left;
        logic       done_q;
        t_result    expected[$];
        int         errors;

        function new();
            addr_q  = '0;
            rd_left = '0;
            wr_left = '0;
            done_q  = 1'b1;
            errors  = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function t_result decode(t_item w);
            t_result    r;
            logic [4:0] entry;
            r = '0;
            entry = w.status_code[7:STATUS_SHIFT];
            case (w.op)
                OP_BEGIN_RD, OP_BEGIN_WR: begin
                    if (w.xfer_length == 8'd0) begin
                        done_q = 1'b1;
                    end else begin
                        addr_q = {w.target_addr, w.op == OP_BEGIN_RD};
                        if (w.op == OP_BEGIN_RD) rd_left = w.xfer_length;
                        else wr_left = w.xfer_length;
                        r.ctl_set = CTL_STA;
                        done_q = 1'b0;
                    end
                end
                OP_STATUS: begin
                    case (entry)
                        ST_BUS_ERR: r.ctl_set = CTL_STO;
                        ST_START, ST_RSTART: begin
                            r.dat_write_valid = 1'b1;
                            r.dat_write_value = addr_q;
                            r.ctl_set = CTL_AA;
                            r.ctl_clear = CTL_STA | CTL_STO;
                        end
                        ST_SLAW_ACK: begin
                            r.dat_write_valid = 1'b1;
                            r.dat_write_value = w.tx_byte;
                            r.ctl_set = CTL_AA;
                            r.ctl_clear = CTL_STA | CTL_STO;
                        end
                        ST_SLAW_NAK, ST_TXD_NAK: begin
                            r.ctl_set = CTL_STO;
                            done_q = 1'b1;
                        end
                        ST_TXD_ACK: begin
                            r.tx_taken = 1'b1;
                            // count of zero or one means last byte
                            if (wr_left <= 8'd1) begin
                                wr_left = '0;
                                r.ctl_clear = CTL_STA;
                                r.ctl_set = CTL_STO;
                                done_q = 1'b1;
                            end else begin
                                wr_left = wr_left - 8'd1;
                                r.dat_write_valid = 1'b1;
                                r.dat_write_value = w.tx_byte;
                                r.ctl_set = CTL_AA;
                                r.ctl_clear = CTL_STA | CTL_STO;
                            end
                        end
                        ST_ARB_LOST: r.ctl_set = CTL_STA;
                        ST_SLAR_ACK: begin
                            if (rd_left == 8'd1) r.ctl_clear = CTL_AA;
                            else r.ctl_set = CTL_AA;
                        end
                        ST_SLAR_NAK: begin
                            r.ctl_set = CTL_AA | CTL_STO;
                            done_q = 1'b1;
                        end
                        ST_RXD_ACK: begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = w.bus_data;
                            if (rd_left != 8'd0) rd_left = rd_left - 8'd1;
                            // withhold ack ahead of the last byte
                            if (rd_left == 8'd1) r.ctl_clear = CTL_AA;
                            else r.ctl_set = CTL_AA;
                        end
                        ST_RXD_NAK: begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = w.bus_data;
                            if (rd_left != 8'd0) rd_left = rd_left - 8'd1;
                            r.ctl_set = CTL_AA | CTL_STO;
                            done_q = 1'b1;
                        end
                        default: begin
                            if (entry >= ST_SLV_LO && entry <= ST_SLV_HI)
                                r.slave_status = 1'b1;
                            else if (entry >= ST_INV_LO && entry <= ST_INV_HI)
                                r.invalid_status = 1'b1;
                        end
                    endcase
                end
                default: ;
            endcase
            r.done_res = done_q;
            return r;
        endfunction

        function void note_input(t_item w);
            expected.push_back(decode(w));
        endfunction

        task cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = expected.pop_front();
                cmp_field("ctl_set", 8'(got.ctl_set), 8'(want.ctl_set));
                cmp_field("ctl_clear", 8'(got.ctl_clear), 8'(want.ctl_clear));
                cmp_field("dat_write_valid", 8'(got.dat_write_valid),
                          8'(want.dat_write_valid));
                cmp_field("dat_write_value", got.dat_write_value, want.dat_write_value);
                cmp_field("tx_taken", 8'(got.tx_taken), 8'(want.tx_taken));
                cmp_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
                cmp_field("rx_byte", got.rx_byte, want.rx_byte);
                cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
                cmp_field("slave_status", 8'(got.slave_status), 8'(want.slave_status));
                cmp_field("invalid_status", 8'(got.invalid_status),
                          8'(want.invalid_status));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_op;
    logic [6:0] i_target_addr;
    logic [7:0] i_xfer_length;
    logic [7:0] i_status_code;
    logic [7:0] i_bus_data;
    logic [7:0] i_tx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_ctl_set;
    logic [2:0] o_ctl_clear;
    logic       o_dat_write_valid;
    logic [7:0] o_dat_write_value;
    logic       o_tx_taken;
    logic       o_rx_valid;
    logic [7:0] o_rx_byte;
    logic       o_done_res;
    logic       o_slave_status;
    logic       o_invalid_status;

    t_item            in_word;
    t_result          out_word;
    status_scoreboard sb;
    int               burst_left = 0;
    int               word_count = 0;
    int               idle_cycles = 0;
    logic [1:0]       stall_mode = '0;
    logic [5:0]       stall_cnt = '0;

    i2c_master_status_sequencer_top dut (.*);

    always #5 i_clk = ~i_clk;

    assign in_word = {i_op, i_target_addr, i_xfer_length, i_status_code, i_bus_data, i_tx_byte};
    assign out_word = {o_ctl_set, o_ctl_clear, o_dat_write_valid, o_dat_write_value,
                       o_tx_taken, o_rx_valid, o_rx_byte, o_done_res, o_slave_status,
                       o_invalid_status};

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(in_word);
            if (o_valid && !i_stall) sb.check_result(out_word);
        end
    end

    // receiver stall pattern, mode re-picked at random each time the 6-bit counter wraps
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 6'd1;
        if (stall_cnt == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= 1'($urandom_range(0, 1));
            2'd2: i_stall <= stall_cnt[2:0] < 3'd3;
            default: i_stall <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("i2c_master_status_sequencer_top test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [2:0] rand_low();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
    endfunction

    function automatic t_item mk_status(logic [4:0] entry, logic [2:0] low,
                                        logic [7:0] bdata, logic [7:0] txb);
        t_item w;
        w.op          = OP_STATUS;
        w.target_addr = 7'($urandom);
        w.xfer_length = 8'($urandom);
        w.status_code = {entry, low};
        w.bus_data    = bdata;
        w.tx_byte     = txb;
        return w;
    endfunction

    function automatic t_item mk_begin(logic [1:0] op, logic [6:0] addr, logic [7:0] len);
        t_item w;
        w.op          = op;
        w.target_addr = addr;
        w.xfer_length = len;
        w.status_code = 8'($urandom);
        w.bus_data    = 8'($urandom);
        w.tx_byte     = 8'($urandom);
        return w;
    endfunction

    task automatic send_item(t_item w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        if (w.op != OP_UNUSED) word_count++;
        i_valid       <= 1'b1;
        i_op          <= w.op;
        i_target_addr <= w.target_addr;
        i_xfer_length <= w.xfer_length;
        i_status_code <= w.status_code;
        i_bus_data    <= w.bus_data;
        i_tx_byte     <= w.tx_byte;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic rand_status(logic [4:0] entry);
        send_item(mk_status(entry, rand_low(), 8'($urandom), 8'($urandom)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(9, 255))
                                            : 8'($urandom_range(1, 5));
    endfunction

    task automatic run_write();
        logic [7:0] len;
        int         acks;
        len = pick_len();
        send_item(mk_begin(OP_BEGIN_WR, 7'($urandom), len));
        if ($urandom_range(0, 7) == 0) begin
            rand_status(ST_ARB_LOST);
            rand_status(ST_RSTART);
        end else begin
            rand_status(ST_START);
        end
        if ($urandom_range(0, 9) == 0) begin
            rand_status(ST_SLAW_NAK);
            return;
        end
        rand_status(ST_SLAW_ACK);
        acks = (len > 8'd8) ? 8 : int'(len);
        for (int i = 0; i < acks; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                rand_status(ST_TXD_NAK);
                return;
            end
            rand_status(ST_TXD_ACK);
        end
        // long writes are cut short by the slave
        if (len > 8'(acks)) rand_status(ST_TXD_NAK);
    endtask

    task automatic run_read();
        logic [7:0] len;
        int         n;
        len = pick_len();
        send_item(mk_begin(OP_BEGIN_RD, 7'($urandom), len));
        if ($urandom_range(0, 7) == 0) begin
            rand_status(ST_ARB_LOST);
            rand_status(ST_RSTART);
        end else begin
            rand_status(ST_START);
        end
        if ($urandom_range(0, 9) == 0) begin
            rand_status(ST_SLAR_NAK);
            return;
        end
        rand_status(ST_SLAR_ACK);
        n = (len > 8'd8) ? 8 : int'(len);
        for (int i = 1; i < n; i++) rand_status(ST_RXD_ACK);
        rand_status(ST_RXD_NAK);
    endtask

    task automatic send_noise();
        t_item w;
        w = t_item'({$urandom, $urandom});
        w.op = 2'($urandom_range(0, 3));
        send_item(w);
    endtask

    initial begin
        t_item w;
        int    pick;
        sb = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_op          = '0;
        i_target_addr = '0;
        i_xfer_length = '0;
        i_status_code = '0;
        i_bus_data    = '0;
        i_tx_byte     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start event while idle, zero length, unused op
        send_item(mk_status(ST_START, 3'd0, 8'h00, 8'h00));
        send_item(mk_begin(OP_BEGIN_WR, 7'h7F, 8'd0));
        w = mk_begin(OP_BEGIN_RD, 7'h11, 8'd4);
        w.op = OP_UNUSED;
        send_item(w);
        // two byte write, then an extra ack with the count at zero
        send_item(mk_begin(OP_BEGIN_WR, 7'h55, 8'd2));
        send_item(mk_status(ST_START, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_SLAW_ACK, 3'd0, 8'h00, 8'hFF));
        send_item(mk_status(ST_TXD_ACK, 3'd0, 8'hFF, 8'h00));
        send_item(mk_status(ST_TXD_ACK, 3'd7, 8'h00, 8'hFF));
        send_item(mk_status(ST_TXD_ACK, 3'd0, 8'h5A, 8'hA5));
        // single byte read, then a receive with the count at zero
        send_item(mk_begin(OP_BEGIN_RD, 7'h2A, 8'd1));
        send_item(mk_status(ST_RSTART, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_SLAR_ACK, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_RXD_NAK, 3'd0, 8'hFF, 8'h00));
        send_item(mk_status(ST_RXD_ACK, 3'd0, 8'h00, 8'hFF));
        send_item(mk_begin(OP_BEGIN_RD, 7'h00, 8'd255));
        send_item(mk_status(ST_ARB_LOST, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_SLAR_NAK, 3'd0, 8'h00, 8'h00));
        send_item(mk_begin(OP_BEGIN_WR, 7'h3C, 8'd3));
        send_item(mk_status(ST_SLAW_NAK, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_TXD_NAK, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_BUS_ERR, 3'd0, 8'h00, 8'h00));
        // slave, invalid and no-action codes
        send_item(mk_status(ST_SLV_LO, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_SLV_HI, 3'd7, 8'h00, 8'h00));
        send_item(mk_status(ST_INV_LO, 3'd0, 8'h00, 8'h00));
        send_item(mk_status(ST_INV_HI, 3'd7, 8'h00, 8'h00));
        send_item(mk_status(ST_NO_ACTION, 3'd7, 8'h00, 8'h00));
        drain();

        word_count = 0;
        while (word_count < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) run_write();
            else if (pick < 75) run_read();
            else repeat ($urandom_range(1, 4)) send_noise();
            if ($urandom_range(0, 49) == 0) drain();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("i2c_master_status_sequencer_top test passed");
        end else begin
            $display("i2c_master_status_sequencer_top test failed");
        end
        $finish;
    end

endmodule
